>>> hdl/spq_pkg.sv
// shared types, codes and sizes for the stable priority queue
package spq_pkg;

  localparam int DEPTH   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 6;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t         opcode;
    logic [1:0]  priority_req;
    logic [15:0] patient_code;
    logic [15:0] nurse_code;
    logic [15:0] doctor_code;
    logic [23:0] entry_date;
    logic [10:0] entry_time;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  head_priority;
    logic [15:0] head_patient;
    logic [15:0] head_nurse;
    logic [15:0] head_doctor;
    logic [23:0] head_date;
    logic [10:0] head_time;
    logic [5:0]  total_count;
    logic [5:0]  nonurgent_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  prio;
    logic [15:0] patient;
    logic [15:0] nurse;
    logic [15:0] doctor;
    logic [23:0] date;
    logic [10:0] minutes;
  } slot_t;

  typedef struct packed {
    logic  insert;
    logic  remove;
    slot_t entry;
  } cell_ctl_t;

  // low bits of a stored count, zero extended when the count is narrow
  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] v);
    logic [CNT_W+COUNT_W-1:0] wide;
    wide = {{COUNT_W{1'b0}}, v};
    return wide[COUNT_W-1:0];
  endfunction

endpackage

>>> hdl/spq_cell.sv
// one slot of the sorted queue with its insert and shift logic
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  logic              prev_after,
  input  spq_pkg::slot_t    prev_entry,
  input  spq_pkg::slot_t    next_entry,
  output logic              after,
  output spq_pkg::slot_t    entry
);
  import spq_pkg::*;

  // stored entry stays ahead of a new one of equal or lower urgency
  assign after = occ && (entry.prio <= ctl.entry.prio);

  always_ff @(posedge clk) begin
    if (ctl.insert && !after) begin
      entry <= prev_after ? ctl.entry : prev_entry;
    end else if (ctl.remove) begin
      entry <= next_entry;
    end
  end

endmodule

>>> hdl/stable_priority_queue_unit.sv
// stable priority queue: row of sorted slot cells, counters and result register
// result: each accepted item's result is registered, valid in the next cycle
// throughput: one item per cycle unless stalled; cells shift or load on acceptance
// backpressure: a new item is taken while the result register is empty or being drained
// reset: clears the fill and non-urgent counts and the result valid
// reset: slot contents are left undefined; only slots below the fill count are read
module stable_priority_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  // occupancy and urgency counters
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] nonurg, nonurg_next;

  logic      accept;
  logic      full, empty;
  logic      do_ins, do_rem;
  cell_ctl_t ctl;
  rsp_t      rsp_next;

  // cell row wiring
  logic        occ   [DEPTH];
  logic        after [DEPTH];
  slot_t       slots [DEPTH];
  logic        prev_after [DEPTH];
  slot_t       prev_entry [DEPTH];
  slot_t       next_entry [DEPTH];

  // the result register parts the two sides; stall only when it is held
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (fill >= CNT_W'(DEPTH));
  assign empty = (fill == '0);

  // dropped inserts and removes on empty leave the row untouched
  assign do_ins = accept && (req.opcode == OP_INSERT) && !full;
  assign do_rem = accept && (req.opcode == OP_REMOVE) && !empty;

  always_comb begin
    ctl.insert        = do_ins;
    ctl.remove        = do_rem;
    ctl.entry.prio    = req.priority_req;
    ctl.entry.patient = req.patient_code;
    ctl.entry.nurse   = req.nurse_code;
    ctl.entry.doctor  = req.doctor_code;
    ctl.entry.date    = req.entry_date;
    ctl.entry.minutes = req.entry_time;
  end

  // chain of cells: each sees its left neighbor for inserts, right for removes
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < fill);

    if (i == 0) begin : g_head
      // the head slot always takes the new entry if it is displaced
      assign prev_after[i] = 1'b1;
      assign prev_entry[i] = ctl.entry;
    end else begin : g_body
      assign prev_after[i] = after[i-1];
      assign prev_entry[i] = slots[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // tail slot falls out of the occupied range on a remove
      assign next_entry[i] = slots[i];
    end else begin : g_mid
      assign next_entry[i] = slots[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ[i]),
      .prev_after (prev_after[i]),
      .prev_entry (prev_entry[i]),
      .next_entry (next_entry[i]),
      .after      (after[i]),
      .entry      (slots[i])
    );
  end

  // counter updates and the result item
  always_comb begin
    fill_next   = fill;
    nonurg_next = nonurg;
    if (do_ins) begin
      fill_next = fill + CNT_W'(1);
      if (req.priority_req != 2'd0) begin
        nonurg_next = nonurg + CNT_W'(1);
      end
    end else if (do_rem) begin
      fill_next = fill - CNT_W'(1);
      if (slots[0].prio != 2'd0 && nonurg != '0) begin
        nonurg_next = nonurg - CNT_W'(1);
      end
    end

    rsp_next               = '0;
    rsp_next.status        = ST_DONE;
    if (req.opcode == OP_INSERT && full) begin
      rsp_next.status = ST_FULL;
    end else if (req.opcode == OP_REMOVE && empty) begin
      rsp_next.status = ST_EMPTY;
    end
    // head fields carry the removed entry, zero on anything else
    if (do_rem) begin
      rsp_next.head_priority = slots[0].prio;
      rsp_next.head_patient  = slots[0].patient;
      rsp_next.head_nurse    = slots[0].nurse;
      rsp_next.head_doctor   = slots[0].doctor;
      rsp_next.head_date     = slots[0].date;
      rsp_next.head_time     = slots[0].minutes;
    end
    rsp_next.total_count     = to_count(fill_next);
    rsp_next.nonurgent_count = to_count(nonurg_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      nonurg    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      fill   <= fill_next;
      nonurg <= nonurg_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload only loads on accept, so a stalled result holds
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  // fill count never runs past the row
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // non-urgent entries are a subset of stored ones
  a_nonurg_bound: assert property (@(posedge clk) disable iff (rst)
    nonurg <= fill)
    else $error("non-urgent count exceeds fill count");

  // a remove on a non-empty store drops the fill by one
  a_remove_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == OP_REMOVE && fill != '0) |=>
      (fill == $past(fill) - CNT_W'(1)))
    else $error("remove did not shrink the queue");

  // every accepted item yields a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted item produced no result");
`endif

endmodule
